FILE: hdl/lhp_pkg.sv
// Shared types and constants of the latency histogram percentile block.
package lhp_pkg;

  localparam int MODE_W = 2;
  localparam int DUR_W  = 32;
  localparam int PCT_W  = 7;
  localparam int CNT_W  = 32;
  localparam int TOT_W  = 64;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_RECORD = 2'd0;
  localparam mode_t MODE_QUERY  = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BIN,
    ST_WR,
    ST_WALK,
    ST_SCALE,
    ST_CLEAR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] duration;
  } bin_req_t;

endpackage

FILE: hdl/lhp_if.sv
// Valid/ready channel interfaces for command words and result words.
interface lhp_in_if;
  import lhp_pkg::*;

  logic             valid;
  logic             ready;
  mode_t            mode;
  logic [DUR_W-1:0] duration_ns;
  logic [PCT_W-1:0] percentile;

  modport source (output valid, output mode, output duration_ns, output percentile,
                  input ready);
  modport sink (input valid, input mode, input duration_ns, input percentile,
                output ready);
endinterface

interface lhp_out_if;
  import lhp_pkg::*;

  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] percentile_ns;
  logic [TOT_W-1:0] total_ns;
  logic [DUR_W-1:0] max_ns;
  logic [CNT_W-1:0] sample_count;

  modport source (output valid, output percentile_ns, output total_ns, output max_ns,
                  output sample_count, input ready);
  modport sink (input valid, input percentile_ns, input total_ns, input max_ns,
                input sample_count, output ready);
endinterface

FILE: hdl/lhp_bucket_mem.sv
// Histogram bucket memory with one write port and one registered read port.
module lhp_bucket_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lhp_bin_calc.sv
// Bucket index pipeline: ceil(duration / BUCKET_NS) clamped, via reciprocal multiply.
module lhp_bin_calc #(
  parameter int BUCKETS   = 64,
  parameter int BUCKET_NS = 1024,
  parameter int IDX_W     = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lhp_pkg::bin_req_t req,
  output logic              done,
  output logic [IDX_W-1:0]  idx
);
  import lhp_pkg::*;

  localparam int NB_W = DUR_W + 1;
  localparam int MUL_W = 2 * DUR_W + 1;
  localparam logic [63:0] LIM64 = 64'(BUCKETS - 2) * 64'(BUCKET_NS);
  localparam logic [DUR_W-1:0] CLAMP_LIM = DUR_W'(LIM64);
  localparam logic [63:0] RECIP64 = (64'd1 << DUR_W) / 64'(BUCKET_NS);
  localparam logic [DUR_W:0] RECIP = (DUR_W + 1)'(RECIP64);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);

  logic [DUR_W-1:0] x_r;
  logic             clamp_r;
  logic             zero_r;
  logic [IDX_W-1:0] q0_r;
  logic [NB_W-1:0]  nb_r;
  logic [IDX_W-1:0] idx_r;
  logic [3:0]       v_r;
  logic [MUL_W-1:0] prod;
  logic             corr;

  // The estimate q0 is the true quotient of (duration - 1) or one below it.
  assign prod = MUL_W'(x_r) * MUL_W'(RECIP);
  assign corr = {1'b0, x_r} >= nb_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r     <= req.duration - DUR_W'(1);
      clamp_r <= req.duration > CLAMP_LIM;
      zero_r  <= req.duration == '0;
    end
    q0_r <= prod[DUR_W +: IDX_W];
    nb_r <= (NB_W'(q0_r) + NB_W'(1)) * NB_W'(BUCKET_NS);
    if (clamp_r) begin
      idx_r <= LAST;
    end else if (zero_r) begin
      idx_r <= '0;
    end else begin
      idx_r <= q0_r + IDX_W'(1) + IDX_W'(corr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], req.start};
    end
  end

  assign done = v_r[3];
  assign idx  = idx_r;

endmodule

FILE: hdl/latency_histogram_percentile.sv
// Top level of the latency histogram percentile block with its controller.
//
//   Port       Dir  Contents
//   in_word    in   mode, duration_ns, percentile
//   out_word   out  percentile_ns, total_ns, max_ns, sample_count
//
// One word is worked on at a time. A record passes through the accept, the bucket index
// pipeline, a read of the bucket, one write and the loading of the result. A query reads
// the buckets in order from bucket 0 until its rank is reached or the last bucket, then
// scales; an empty or out-of-range query goes straight to the result. Reset and a clear
// sweep the bucket memory to zero without accepting a word. A waiting result does not
// block the next accept; it stalls only the next result.
module latency_histogram_percentile #(
  parameter int BUCKETS   = 64,
  parameter int BUCKET_NS = 1024
) (
  input logic clk,
  input logic rst_n,
  lhp_in_if.sink    in_word,
  lhp_out_if.source out_word
);
  import lhp_pkg::*;

  localparam int IDX_W = $clog2(BUCKETS);
  localparam int PTR_W = IDX_W + 1;
  localparam int TGT_W = CNT_W + PCT_W;
  localparam int ACC_W = TGT_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUCKETS - 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(BUCKETS);

  state_t state_r, state_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [DUR_W-1:0] max_r, max_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [TGT_W-1:0] target_r, target_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W-1:0] m_r, m_nxt;
  logic [IDX_W-1:0] a1_r, a1_nxt;
  logic [IDX_W-1:0] a2_r, a2_nxt;
  logic             v1_r, v1_nxt;
  logic             v2_r, v2_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [DUR_W-1:0] pct_r, pct_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DUR_W-1:0] out_pct_r, out_pct_nxt;
  logic [TOT_W-1:0] out_total_r, out_total_nxt;
  logic [DUR_W-1:0] out_max_r, out_max_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  bin_req_t         bin_req;
  logic             bin_done;
  logic [IDX_W-1:0] bin_idx;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [CNT_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [CNT_W-1:0] mem_rd_data;
  logic [ACC_W-1:0] acc_sum;
  logic             hit;
  logic             in_fire;

  lhp_bin_calc #(
    .BUCKETS  (BUCKETS),
    .BUCKET_NS(BUCKET_NS),
    .IDX_W    (IDX_W)
  ) u_bin_calc (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (bin_req),
    .done (bin_done),
    .idx  (bin_idx)
  );

  lhp_bucket_mem #(
    .DEPTH(BUCKETS),
    .AW   (IDX_W),
    .DW   (CNT_W)
  ) u_bucket_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  // The rank test acc >= ceil(count * p / 100) is done as 100 * acc >= count * p.
  assign acc_sum = acc_r + m_r;
  assign hit     = v2_r && (acc_sum >= ACC_W'(target_r));
  assign in_fire = in_word.valid && in_word.ready;

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    max_nxt       = max_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    m_nxt         = ACC_W'(mem_rd_data) * ACC_W'(PCT_FULL);
    a1_nxt        = ptr_r[IDX_W-1:0];
    a2_nxt        = a1_r;
    v1_nxt        = 1'b0;
    v2_nxt        = 1'b0;
    hit_idx_nxt   = hit_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_pct_nxt   = out_pct_r;
    out_total_nxt = out_total_r;
    out_max_nxt   = out_max_r;
    out_count_nxt = out_count_r;
    in_word.ready = 1'b0;
    bin_req       = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = ptr_r[IDX_W-1:0];
    mem_wr_data   = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = ptr_r[IDX_W-1:0];
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_wr_en = 1'b1;
        ptr_nxt   = ptr_r + PTR_W'(1);
        if (ptr_r[IDX_W-1:0] == LAST) begin
          ptr_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        in_word.ready = 1'b1;
        pct_nxt       = '0;
        if (in_word.valid) begin
          case (in_word.mode)
            MODE_RECORD: begin
              total_nxt = total_r + TOT_W'(in_word.duration_ns);
              if (in_word.duration_ns > max_r) begin
                max_nxt = in_word.duration_ns;
              end
              if (count_r != '1) begin
                count_nxt = count_r + CNT_W'(1);
              end
              bin_req.start    = 1'b1;
              bin_req.duration = in_word.duration_ns;
              state_nxt        = ST_BIN;
            end
            MODE_QUERY: begin
              if (count_r == '0 || in_word.percentile == '0 ||
                  in_word.percentile > PCT_FULL) begin
                state_nxt = ST_RESP;
              end else begin
                target_nxt = TGT_W'(count_r) * TGT_W'(in_word.percentile);
                acc_nxt    = '0;
                ptr_nxt    = '0;
                state_nxt  = ST_WALK;
              end
            end
            MODE_CLEAR: begin
              total_nxt = '0;
              max_nxt   = '0;
              count_nxt = '0;
              ptr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_BIN: begin
        if (bin_done) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = bin_idx;
          wr_idx_nxt  = bin_idx;
          state_nxt   = ST_WR;
        end
      end
      ST_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = wr_idx_r;
        mem_wr_data = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + CNT_W'(1);
        state_nxt   = ST_RESP;
      end
      ST_WALK: begin
        if (ptr_r < PTR_END) begin
          mem_rd_en = 1'b1;
          ptr_nxt   = ptr_r + PTR_W'(1);
          v1_nxt    = 1'b1;
        end
        v2_nxt = v1_r;
        if (v2_r) begin
          acc_nxt = acc_sum;
          if (hit || a2_r == LAST) begin
            hit_idx_nxt = a2_r;
            v1_nxt      = 1'b0;
            v2_nxt      = 1'b0;
            state_nxt   = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (hit_idx_r == LAST) begin
          pct_nxt = max_r;
        end else begin
          pct_nxt = DUR_W'(hit_idx_r) * DUR_W'(BUCKET_NS);
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt = 1'b1;
          out_pct_nxt   = pct_r;
          out_total_nxt = total_r;
          out_max_nxt   = max_r;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      ptr_r       <= '0;
      total_r     <= '0;
      max_r       <= '0;
      count_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      total_r     <= total_nxt;
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r    <= target_nxt;
    acc_r       <= acc_nxt;
    m_r         <= m_nxt;
    a1_r        <= a1_nxt;
    a2_r        <= a2_nxt;
    hit_idx_r   <= hit_idx_nxt;
    wr_idx_r    <= wr_idx_nxt;
    pct_r       <= pct_nxt;
    out_pct_r   <= out_pct_nxt;
    out_total_r <= out_total_nxt;
    out_max_r   <= out_max_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.percentile_ns = out_pct_r;
  assign out_word.total_ns      = out_total_r;
  assign out_word.max_ns        = out_max_r;
  assign out_word.sample_count  = out_count_r;

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.mode == MODE_RECORD && count_r != '1
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("sample count did not advance on a record");

  a_max_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_word.mode == MODE_RECORD |=> max_r >= $past(in_word.duration_ns))
    else $error("running maximum below a recorded duration");

  a_walk_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK || state_r == ST_SCALE |-> !mem_wr_en)
    else $error("bucket memory written during a query");

  a_bin_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    bin_done |-> state_r == ST_BIN)
    else $error("bucket index finished outside of a record");

endmodule
